>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> sv/sio_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sio_pkg
// Types and constants shared by the I/O expander modules.
// ----------------------------------------------------------------------------
package sio_pkg;

	localparam int MASK_W  = 32;
	localparam int THRESH_W = 8;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd3;
	localparam logic [THRESH_W-1:0] MATCH_MAX    = 8'hFF;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_READ  = 3'd1,
		ACT_SCAN  = 3'd2,
		ACT_SHIFT = 3'd3,
		ACT_TICK  = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_LOAD_LOW   = 4'd1,
		PH_LOAD_HIGH  = 4'd2,
		PH_SAMPLE     = 4'd3,
		PH_ICLK_LOW   = 4'd4,
		PH_ODATA      = 4'd5,
		PH_OCLK_HIGH  = 4'd6,
		PH_LATCH_LOW  = 4'd7,
		PH_LATCH_HIGH = 4'd8
	} phase_t;

	typedef struct packed {
		logic load;
		logic iclk;
		logic odata;
		logic oclk;
		logic latch;
	} pins_t;

	localparam pins_t PINS_RESET = '{load: 1'b1, iclk: 1'b0, odata: 1'b0,
		oclk: 1'b1, latch: 1'b1};

	typedef struct packed {
		logic [2:0]        action;
		logic [MASK_W-1:0] pin_mask;
		logic              pin_value;
		logic              bank_select;
		logic              serial_in;
	} item_t;

	typedef struct packed {
		logic  read_bit;
		pins_t pins;
		logic  busy;
	} result_t;

	// engine status seen by the top level
	typedef struct packed {
		pins_t pins;
		logic  idle;
	} status_t;

endpackage

>>> sv/sio_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sio_engine
// Image registers, debounce state and pin sequencer; one item per fire.
// ----------------------------------------------------------------------------
module sio_engine #(
	parameter int INPUT_BITS  = 32,
	parameter int OUTPUT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  sio_pkg::item_t                  item,
	input  logic [sio_pkg::THRESH_W-1:0]    threshold,
	output sio_pkg::result_t                result,
	output sio_pkg::status_t                status
);

	localparam int SW = (INPUT_BITS > OUTPUT_BITS) ? INPUT_BITS : OUTPUT_BITS;
	localparam int CW = $clog2(SW + 1);
	localparam int IW = $clog2(SW);

	logic [OUTPUT_BITS-1:0]        out_img_q, out_img_d;
	logic [INPUT_BITS-1:0]         in_img_q, in_img_d;
	logic [INPUT_BITS-1:0]         prev_q, prev_d;
	logic [sio_pkg::THRESH_W-1:0]  match_q, match_d, match_fin;
	logic [SW-1:0]                 shift_q, shift_d;
	logic [CW-1:0]                 cnt_q, cnt_d, cnt_dec;
	sio_pkg::phase_t               phase_q, phase_d;
	sio_pkg::pins_t                pins_q, pins_d;
	logic                          rd;
	logic [IW-1:0]                 bidx;
	logic                          bit_ok;
	logic [INPUT_BITS-1:0]         word;
	logic [OUTPUT_BITS-1:0]        wmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_img_q <= '0;
			in_img_q  <= '0;
			prev_q    <= '0;
			match_q   <= '0;
			shift_q   <= '0;
			cnt_q     <= '0;
			phase_q   <= sio_pkg::PH_IDLE;
			pins_q    <= sio_pkg::PINS_RESET;
		end else if (fire) begin
			out_img_q <= out_img_d;
			in_img_q  <= in_img_d;
			prev_q    <= prev_d;
			match_q   <= match_d;
			shift_q   <= shift_d;
			cnt_q     <= cnt_d;
			phase_q   <= phase_d;
			pins_q    <= pins_d;
		end
	end

	assign cnt_dec = (cnt_q != '0) ? cnt_q - CW'(1) : cnt_q;
	assign bidx    = IW'(cnt_q - CW'(1));
	assign bit_ok  = (cnt_q != '0) && (cnt_q <= CW'(SW));
	assign word    = shift_q[INPUT_BITS-1:0];
	assign wmask   = item.pin_mask[OUTPUT_BITS-1:0];

	// saturating count of equal successive scans
	always_comb begin
		if (word == prev_q) begin
			match_fin = (match_q == sio_pkg::MATCH_MAX) ? match_q
				: match_q + sio_pkg::THRESH_W'(1);
		end else begin
			match_fin = '0;
		end
	end

	always_comb begin
		out_img_d = out_img_q;
		in_img_d  = in_img_q;
		prev_d    = prev_q;
		match_d   = match_q;
		shift_d   = shift_q;
		cnt_d     = cnt_q;
		phase_d   = phase_q;
		pins_d    = pins_q;
		rd        = 1'b0;

		unique case (sio_pkg::action_t'(item.action))
			sio_pkg::ACT_WRITE: begin
				out_img_d = item.pin_value ? (out_img_q | wmask) : (out_img_q & ~wmask);
			end
			sio_pkg::ACT_READ: begin
				rd = item.bank_select ? |(out_img_q & wmask)
					: |(in_img_q & item.pin_mask[INPUT_BITS-1:0]);
			end
			sio_pkg::ACT_SCAN: begin
				if (phase_q == sio_pkg::PH_IDLE) begin
					pins_d.load = 1'b1;
					shift_d     = '0;
					cnt_d       = '0;
					phase_d     = sio_pkg::PH_LOAD_LOW;
				end
			end
			sio_pkg::ACT_SHIFT: begin
				if (phase_q == sio_pkg::PH_IDLE) begin
					shift_d = SW'(out_img_q);
					cnt_d   = CW'(OUTPUT_BITS);
					phase_d = sio_pkg::PH_ODATA;
				end
			end
			sio_pkg::ACT_TICK: begin
				unique case (phase_q)
					sio_pkg::PH_LOAD_LOW: begin
						pins_d.load = 1'b0;
						phase_d     = sio_pkg::PH_LOAD_HIGH;
					end
					sio_pkg::PH_LOAD_HIGH: begin
						pins_d.load = 1'b1;
						cnt_d       = CW'(INPUT_BITS);
						phase_d     = sio_pkg::PH_SAMPLE;
					end
					sio_pkg::PH_SAMPLE: begin
						if (bit_ok && item.serial_in)
							shift_d[bidx] = 1'b1;
						pins_d.iclk = 1'b1;
						phase_d     = sio_pkg::PH_ICLK_LOW;
					end
					sio_pkg::PH_ICLK_LOW: begin
						pins_d.iclk = 1'b0;
						cnt_d       = cnt_dec;
						if (cnt_dec == '0) begin
							match_d = match_fin;
							prev_d  = word;
							if (match_fin >= threshold)
								in_img_d = ~word;
							phase_d = sio_pkg::PH_IDLE;
						end else begin
							phase_d = sio_pkg::PH_SAMPLE;
						end
					end
					sio_pkg::PH_ODATA: begin
						if (bit_ok)
							pins_d.odata = shift_q[bidx];
						pins_d.oclk = 1'b0;
						phase_d     = sio_pkg::PH_OCLK_HIGH;
					end
					sio_pkg::PH_OCLK_HIGH: begin
						pins_d.oclk = 1'b1;
						cnt_d       = cnt_dec;
						phase_d     = (cnt_dec == '0) ? sio_pkg::PH_LATCH_LOW
							: sio_pkg::PH_ODATA;
					end
					sio_pkg::PH_LATCH_LOW: begin
						pins_d.latch = 1'b0;
						phase_d      = sio_pkg::PH_LATCH_HIGH;
					end
					sio_pkg::PH_LATCH_HIGH: begin
						pins_d.latch = 1'b1;
						phase_d      = sio_pkg::PH_IDLE;
					end
					default: begin
						phase_d = sio_pkg::PH_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign result.read_bit = rd;
	assign result.pins     = pins_d;
	assign result.busy     = (phase_d != sio_pkg::PH_IDLE);

	assign status.pins = pins_q;
	assign status.idle = (phase_q == sio_pkg::PH_IDLE);

endmodule

>>> sv/sio_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sio_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module sio_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sio_pkg::result_t result_d,
	input  logic             out_stall,
	output logic             take,
	output logic             out_valid,
	output sio_pkg::result_t result_q
);

	logic valid_q;

	// free when empty or draining this cycle
	assign take = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (take && load) begin
			result_q <= result_d;
		end
	end

	assign out_valid = valid_q;

endmodule

>>> sv/shift_register_io_expander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_register_io_expander
// Serial GPIO expander: input scan with debounce, output shift with latch.
// ----------------------------------------------------------------------------
// Every word on the input channel is one command (write output bits, read a
// bit, start a scan, start an output shift, or tick the pin sequencer) and
// produces exactly one result word holding the read bit, the five pin levels
// after the command and the busy flag. Throughput is one word per clock while
// the output does not stall; a word's result is registered (it sits in the input
// register, then moves into the result register). The command logic between
// the two is a single pass over small images, an INPUT_BITS-wide compare and an
// 8-bit saturating add, so nothing iterates. A stall on the output holds the result
// register and backs up into in_stall the same cycle. A full scan needs the
// start word plus 2 + 2*INPUT_BITS tick words and an output shift the start
// word plus 2*OUTPUT_BITS + 2 tick words. debounce_threshold may only be
// written while no words are in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shift_register_io_expander #(
	parameter int INPUT_BITS  = 32,
	parameter int OUTPUT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    action,
	input  logic [sio_pkg::MASK_W-1:0]    pin_mask,
	input  logic                          pin_value,
	input  logic                          bank_select,
	input  logic                          serial_in,

	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          read_bit,
	output logic                          load_pin,
	output logic                          in_clock_pin,
	output logic                          out_data_pin,
	output logic                          out_clock_pin,
	output logic                          latch_pin,
	output logic                          busy_res,

	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sio_pkg::THRESH_W-1:0]  debounce_threshold
);

	logic                          valid_s1;
	sio_pkg::item_t                item_s1;
	logic                          take;
	logic                          advance;
	logic [sio_pkg::THRESH_W-1:0]  thresh_q;
	sio_pkg::result_t              res_next;
	sio_pkg::result_t              res_q;
	sio_pkg::status_t              status;

	// threshold register; the user must write it only between commands, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= sio_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= debounce_threshold;
		end
	end

	// input register: a held word stalls only if the result slot is full
	assign advance  = valid_s1 && take;
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{action: action, pin_mask: pin_mask, pin_value: pin_value,
				bank_select: bank_select, serial_in: serial_in};
		end
	end

	// state update happens when the word moves into the result register
	sio_engine #(
		.INPUT_BITS  (INPUT_BITS),
		.OUTPUT_BITS (OUTPUT_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.threshold (thresh_q),
		.result    (res_next),
		.status    (status)
	);

	sio_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result_d  (res_next),
		.out_stall (out_stall),
		.take      (take),
		.out_valid (out_valid),
		.result_q  (res_q)
	);

	assign read_bit      = res_q.read_bit;
	assign load_pin      = res_q.pins.load;
	assign in_clock_pin  = res_q.pins.iclk;
	assign out_data_pin  = res_q.pins.odata;
	assign out_clock_pin = res_q.pins.oclk;
	assign latch_pin     = res_q.pins.latch;
	assign busy_res      = res_q.busy;

	// a stall upstream only ever comes from a held word
	`ASSERT_HOLDS(a_stall_has_word, clk, arst_n, in_stall |-> valid_s1)

	// a word leaving the input register always shows up as a result
	`ASSERT_HOLDS(a_advance_gives_result, clk, arst_n, advance |=> out_valid)

	// with the sequencer idle, load, oclk and latch rest high and iclk rests low
	`ASSERT_HOLDS(a_idle_pins_quiet, clk, arst_n,
		status.idle |-> (status.pins.load && status.pins.oclk && status.pins.latch
			&& !status.pins.iclk))

endmodule
